// ----- src/rb_pkg.sv -----
// Shared types and constants for the reorder buffer.
// Used by rb_store, rb_ctrl and reorder_buffer_top; no dependencies.
package rb_pkg;

    localparam int REQ_W      = 3;
    localparam int KIND_W     = 3;
    localparam int PC_W       = 17;
    localparam int REG_W      = 6;
    localparam int PAT_W      = 8;
    localparam int TAG_W      = 6;
    localparam int VAL_W      = 32;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 80;

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC     = 3'd0,
        REQ_COMPLETE  = 3'd1,
        REQ_READ      = 3'd2,
        REQ_RETIRE    = 3'd3,
        REQ_FLUSH     = 3'd4,
        REQ_SPEC_MARK = 3'd5
    } t_req;

    localparam logic [KIND_W-1:0] KIND_NONE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_STORE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_END   = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0]       entry_kind;
        logic signed [PC_W-1:0]  instr_pc;
        logic signed [REG_W-1:0] dest_reg;
        logic                    pred_taken;
        logic [PAT_W-1:0]        hist_pattern;
        logic [TAG_W-1:0]        tag;
        logic signed [VAL_W-1:0] result_value;
        logic                    has_outcome;
        logic                    outcome_taken;
        logic                    spec_flag;
    } t_in;

    // write command from the sequencer to the slot store
    typedef struct packed {
        logic              alloc;
        logic              complete;
        logic              spec_wr;
        logic [KIND_W-1:0] kind;
        logic [PC_W-1:0]   pc;
        logic [REG_W-1:0]  dest;
        logic              pred;
        logic [PAT_W-1:0]  pattern;
        logic [VAL_W-1:0]  value;
        logic              has_outcome;
        logic              outcome;
        logic              spec;
    } t_wr;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [PC_W-1:0]   pc;
        logic [REG_W-1:0]  dest;
        logic [VAL_W-1:0]  value;
        logic              pred;
        logic              taken;
        logic [PAT_W-1:0]  pattern;
        logic              spec;
    } t_slot;

    typedef struct packed {
        logic [TAG_W-1:0]        tag_out;
        logic signed [VAL_W-1:0] value_out;
        logic                    ready_res;
        logic [KIND_W-1:0]       kind_out;
        logic signed [PC_W-1:0]  pc_out;
        logic signed [REG_W-1:0] dest_out;
        logic                    pred_out;
        logic                    taken_out;
        logic [PAT_W-1:0]        pattern_out;
        logic                    spec_out;
        logic                    store_mark;
        logic                    last;
    } t_res;

endpackage

// ----- src/reorder_buffer_top.sv -----
// Top level of the reorder buffer: stream ports, output register and the
// sequencer/storage pair. Depends on rb_pkg, rb_ctrl and rb_store.
//
// Usage:
//   Requests enter on the s_axis channel, the request code in tuser and the
//   operands in tdata. Results leave on m_axis; tlast marks the last result
//   of a request. Allocate and read give one result, retire gives one per
//   committed entry plus a final one that carries the new head tag and the
//   store flag; complete, flush and set speculative give none.
//   One request is in work at a time and s_axis_tready is low meanwhile.
//   A request with no result passes through S_EXEC before tready returns;
//   allocate and read then wait in S_ALLOC or S_READ until the output takes
//   their result. Retire walks S_RT_CHECK and S_RT_EMIT for each committed
//   entry, then S_RT_FIN, as the slot memories give one read per cycle:
//   each entry is read, then checked. Results pass through an output
//   register; if it is full and m_axis_tready is low the sequencer waits
//   with its result held. Reset (synchronous, active low) empties the buffer
//   and clears all done flags; slot fields keep whatever they held.
module reorder_buffer_top #(
    parameter int ROB_DEPTH    = 32,
    parameter int TAG_OFFSET   = 32,
    parameter int RETIRE_WIDTH = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // entry_kind, instr_pc, dest_reg, pred_taken, hist_pattern, tag,
    // result_value, has_outcome, outcome_taken, spec_flag, zero pad
    input  logic [rb_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // req_type
    input  logic [rb_pkg::REQ_W-1:0]        s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tag_out, value_out, ready_res, kind_out, pc_out, dest_out, pred_out,
    // taken_out, pattern_out, spec_out, store_mark, zero pad
    output logic [rb_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                            m_axis_tlast
);
    import rb_pkg::*;

    localparam int PW = $clog2(ROB_DEPTH);

    t_in           in_item;
    t_res          res;
    logic          res_valid;
    logic          res_ready;
    t_wr           wr;
    logic [PW-1:0] wr_addr;
    logic [PW-1:0] rd_addr;
    t_slot         rd_slot;
    logic          rd_done;

    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;
    logic                  r_m_last;

    assign in_item.entry_kind    = s_axis_tdata[2:0];
    assign in_item.instr_pc      = s_axis_tdata[19:3];
    assign in_item.dest_reg      = s_axis_tdata[25:20];
    assign in_item.pred_taken    = s_axis_tdata[26];
    assign in_item.hist_pattern  = s_axis_tdata[34:27];
    assign in_item.tag           = s_axis_tdata[40:35];
    assign in_item.result_value  = s_axis_tdata[72:41];
    assign in_item.has_outcome   = s_axis_tdata[73];
    assign in_item.outcome_taken = s_axis_tdata[74];
    assign in_item.spec_flag     = s_axis_tdata[75];

    rb_ctrl #(
        .ROB_DEPTH    (ROB_DEPTH),
        .TAG_OFFSET   (TAG_OFFSET),
        .RETIRE_WIDTH (RETIRE_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_req       (s_axis_tuser),
        .i_in        (in_item),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_wr        (wr),
        .o_wr_addr   (wr_addr),
        .o_rd_addr   (rd_addr),
        .i_rd_slot   (rd_slot),
        .i_rd_done   (rd_done)
    );

    rb_store #(
        .ROB_DEPTH (ROB_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_wr_addr (wr_addr),
        .i_rd_addr (rd_addr),
        .o_rd_slot (rd_slot),
        .o_rd_done (rd_done)
    );

    // output register takes a new item when empty or being drained
    assign res_ready = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_ready) begin
            r_m_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_m_data <= {3'b000, res.store_mark, res.spec_out, res.pattern_out,
                         res.taken_out, res.pred_out, res.dest_out, res.pc_out,
                         res.kind_out, res.ready_res, res.value_out, res.tag_out};
            r_m_last <= res.last;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

endmodule

// ----- src/rb_store.sv -----
// Slot storage of the reorder buffer: field memories with registered read
// and reset-cleared done flags. Depends on rb_pkg.
module rb_store #(
    parameter int ROB_DEPTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rb_pkg::t_wr                   i_wr,
    input  logic [$clog2(ROB_DEPTH)-1:0]  i_wr_addr,
    input  logic [$clog2(ROB_DEPTH)-1:0]  i_rd_addr,
    output rb_pkg::t_slot                 o_rd_slot,
    output logic                          o_rd_done
);
    import rb_pkg::*;

    localparam int INFO_W = KIND_W + PC_W + REG_W + 1 + PAT_W;

    logic [INFO_W-1:0] r_info_mem  [ROB_DEPTH];
    logic [VAL_W-1:0]  r_value_mem [ROB_DEPTH];
    logic              r_taken_mem [ROB_DEPTH];
    logic              r_spec_mem  [ROB_DEPTH];
    logic [ROB_DEPTH-1:0] r_done;

    logic [INFO_W-1:0] r_info_q;
    logic [VAL_W-1:0]  r_value_q;
    logic              r_taken_q;
    logic              r_spec_q;

    always_ff @(posedge i_clk) begin
        if (i_wr.alloc) begin
            r_info_mem[i_wr_addr] <= {i_wr.kind, i_wr.pc, i_wr.dest, i_wr.pred, i_wr.pattern};
        end
        r_info_q <= r_info_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.alloc) begin
            r_value_mem[i_wr_addr] <= '0;
        end else if (i_wr.complete) begin
            r_value_mem[i_wr_addr] <= i_wr.value;
        end
        r_value_q <= r_value_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.alloc) begin
            r_taken_mem[i_wr_addr] <= 1'b0;
        end else if (i_wr.complete && i_wr.has_outcome) begin
            r_taken_mem[i_wr_addr] <= i_wr.outcome;
        end
        r_taken_q <= r_taken_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.alloc) begin
            r_spec_mem[i_wr_addr] <= 1'b0;
        end else if (i_wr.spec_wr) begin
            r_spec_mem[i_wr_addr] <= i_wr.spec;
        end
        r_spec_q <= r_spec_mem[i_rd_addr];
    end

    // an END entry is born done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= '0;
        end else if (i_wr.alloc) begin
            r_done[i_wr_addr] <= (i_wr.kind == KIND_END);
        end else if (i_wr.complete) begin
            r_done[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_done = r_done[i_rd_addr];

    always_comb begin
        {o_rd_slot.kind, o_rd_slot.pc, o_rd_slot.dest, o_rd_slot.pred, o_rd_slot.pattern}
            = r_info_q;
        o_rd_slot.value = r_value_q;
        o_rd_slot.taken = r_taken_q;
        o_rd_slot.spec  = r_spec_q;
    end

endmodule

// ----- src/rb_ctrl.sv -----
// Request sequencer of the reorder buffer: pointers, occupancy, retire walk
// and result formation. Depends on rb_pkg; drives rb_store.
module rb_ctrl #(
    parameter int ROB_DEPTH    = 32,
    parameter int TAG_OFFSET   = 32,
    parameter int RETIRE_WIDTH = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [rb_pkg::REQ_W-1:0]      i_req,
    input  rb_pkg::t_in                   i_in,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output rb_pkg::t_res                  o_res,
    output rb_pkg::t_wr                   o_wr,
    output logic [$clog2(ROB_DEPTH)-1:0]  o_wr_addr,
    output logic [$clog2(ROB_DEPTH)-1:0]  o_rd_addr,
    input  rb_pkg::t_slot                 i_rd_slot,
    input  logic                          i_rd_done
);
    import rb_pkg::*;

    localparam int PW = $clog2(ROB_DEPTH);
    localparam int CW = $clog2(RETIRE_WIDTH + 1);
    localparam int XW = 10;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_EXEC     = 7'b0000010,
        S_ALLOC    = 7'b0000100,
        S_READ     = 7'b0001000,
        S_RT_CHECK = 7'b0010000,
        S_RT_EMIT  = 7'b0100000,
        S_RT_FIN   = 7'b1000000
    } t_state;

    t_state        r_state, n_state;
    t_req          r_req, n_req;
    t_in           r_in, n_in;
    t_res          r_ares, n_ares;
    logic [PW-1:0] r_ip, n_ip;
    logic [PW-1:0] r_rp, n_rp;
    logic [PW-1:0] r_occ, n_occ;
    logic [CW-1:0] r_cnt, n_cnt;

    logic [XW-1:0] tag_rel;
    logic          tag_ok;
    logic [PW-1:0] tag_idx;
    logic [PW:0]   ptr_dist;

    function automatic logic [TAG_W-1:0] slot_tag(input logic [PW-1:0] idx);
        logic [XW-1:0] s;
        s = XW'(idx) + XW'(TAG_OFFSET);
        return s[TAG_W-1:0];
    endfunction

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(ROB_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign tag_rel = XW'(r_in.tag) - XW'(TAG_OFFSET);
    assign tag_ok  = (XW'(r_in.tag) >= XW'(TAG_OFFSET)) && (tag_rel < XW'(ROB_DEPTH));
    assign tag_idx = tag_rel[PW-1:0];

    assign o_wr_addr = (r_req == REQ_ALLOC) ? r_ip : tag_idx;
    // held for the whole item so the registered read data stays put
    assign o_rd_addr = (r_req == REQ_READ) ? tag_idx : r_rp;

    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        n_in    = r_in;
        n_ares  = r_ares;
        n_ip    = r_ip;
        n_rp    = r_rp;
        n_occ   = r_occ;
        n_cnt   = r_cnt;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;

        o_wr.alloc       = 1'b0;
        o_wr.complete    = 1'b0;
        o_wr.spec_wr     = 1'b0;
        o_wr.kind        = (r_in.entry_kind > KIND_END) ? KIND_NONE : r_in.entry_kind;
        o_wr.pc          = r_in.instr_pc;
        o_wr.dest        = r_in.dest_reg;
        o_wr.pred        = r_in.pred_taken;
        o_wr.pattern     = r_in.hist_pattern;
        o_wr.value       = r_in.result_value;
        o_wr.has_outcome = r_in.has_outcome;
        o_wr.outcome     = r_in.outcome_taken;
        o_wr.spec        = r_in.spec_flag;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_req   = t_req'(i_req);
                    n_in    = i_in;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                unique case (r_req)
                    REQ_ALLOC: begin
                        n_ares      = '0;
                        n_ares.last = 1'b1;
                        // one slot is always kept free
                        if (r_occ < PW'(ROB_DEPTH - 1)) begin
                            o_wr.alloc       = 1'b1;
                            n_ip             = ptr_inc(r_ip);
                            n_occ            = r_occ + 1'b1;
                            n_ares.tag_out   = slot_tag(r_ip);
                            n_ares.ready_res = 1'b1;
                            n_ares.value_out = VAL_W'(ROB_DEPTH - 2) - VAL_W'(r_occ);
                        end else begin
                            n_ares.value_out = VAL_W'(ROB_DEPTH - 1) - VAL_W'(r_occ);
                        end
                        n_state = S_ALLOC;
                    end
                    REQ_COMPLETE: o_wr.complete = tag_ok;
                    REQ_READ:     n_state = S_READ;
                    REQ_RETIRE: begin
                        n_cnt   = '0;
                        n_state = S_RT_CHECK;
                    end
                    REQ_FLUSH: begin
                        n_ip  = r_rp;
                        n_occ = '0;
                    end
                    REQ_SPEC_MARK: o_wr.spec_wr = tag_ok;
                    default: n_state = S_IDLE;
                endcase
            end
            S_ALLOC: begin
                o_res_valid = 1'b1;
                o_res       = r_ares;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                o_res_valid     = 1'b1;
                o_res.tag_out   = r_in.tag;
                o_res.ready_res = tag_ok && i_rd_done;
                o_res.value_out = (tag_ok && i_rd_done) ? i_rd_slot.value
                                                        : VAL_W'(r_in.tag);
                o_res.last      = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_RT_CHECK: begin
                if (i_rd_done && (r_rp != r_ip) && (r_cnt < CW'(RETIRE_WIDTH))) begin
                    n_state = S_RT_EMIT;
                end else begin
                    n_state = S_RT_FIN;
                end
            end
            S_RT_EMIT: begin
                o_res_valid       = 1'b1;
                o_res.tag_out     = slot_tag(r_rp);
                o_res.value_out   = i_rd_slot.value;
                o_res.ready_res   = 1'b1;
                o_res.kind_out    = i_rd_slot.kind;
                o_res.pc_out      = i_rd_slot.pc;
                o_res.dest_out    = i_rd_slot.dest;
                o_res.pred_out    = i_rd_slot.pred;
                o_res.taken_out   = i_rd_slot.taken;
                o_res.pattern_out = i_rd_slot.pattern;
                o_res.spec_out    = i_rd_slot.spec;
                if (i_res_ready) begin
                    n_rp    = ptr_inc(r_rp);
                    n_occ   = (r_occ != '0) ? r_occ - 1'b1 : r_occ;
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_RT_CHECK;
                end
            end
            S_RT_FIN: begin
                o_res_valid      = 1'b1;
                o_res.tag_out    = slot_tag(r_rp);
                o_res.store_mark = (r_rp != r_ip) && (i_rd_slot.kind == KIND_STORE);
                o_res.last       = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_req   <= REQ_ALLOC;
            r_ip    <= '0;
            r_rp    <= '0;
            r_occ   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_req   <= n_req;
            r_ip    <= n_ip;
            r_rp    <= n_rp;
            r_occ   <= n_occ;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_ares <= n_ares;
    end

    assign ptr_dist = (r_ip >= r_rp) ? {1'b0, r_ip} - {1'b0, r_rp}
                                     : {1'b0, r_ip} + (PW+1)'(ROB_DEPTH) - {1'b0, r_rp};

    a_occ_matches_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ptr_dist == (PW+1)'(r_occ))
        else $error("occupancy out of step with pointers");

    a_commit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RT_EMIT) |-> (i_rd_done && (r_rp != r_ip)))
        else $error("committing an entry that is not done");

    a_retire_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RT_EMIT) |-> (r_cnt < CW'(RETIRE_WIDTH)))
        else $error("retire walked past its width");

    a_final_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_ready && o_res.last) |=> (r_state == S_IDLE))
        else $error("sequencer busy after last result");

endmodule
